// ===== src/cmbc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the majority-vote consensus base caller.
// No dependencies.
package cmbc_pkg;

   localparam int NUM_SYMBOLS  = 6;
   localparam int MAX_COVERAGE = 65535;
   localparam int SYM_SLOTS    = 6;
   localparam int CNT_W        = 16;
   localparam int QSUM_W       = 24;
   localparam int SYM_IDX_W    = $clog2(NUM_SYMBOLS);

   localparam logic [CNT_W-1:0]     CNT_MAX  = CNT_W'(MAX_COVERAGE);
   localparam logic [QSUM_W-1:0]    QSUM_MAX = {QSUM_W{1'b1}};
   localparam logic [SYM_IDX_W-1:0] SYM_LAST = SYM_IDX_W'(NUM_SYMBOLS - 1);
   localparam logic [SYM_IDX_W-1:0] SYM_GAP  = '0;
   localparam logic [SYM_IDX_W-1:0] SYM_A    = SYM_IDX_W'(1);

   localparam logic [7:0] CHAR_GAP   = 8'h2D;
   localparam logic [7:0] CHAR_UPPER = 8'h41;
   localparam logic [7:0] CHAR_LOWER = 8'h61;

   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [QSUM_W-1:0]    qsum_type;
   typedef logic [SYM_IDX_W-1:0] sym_idx_type;

   typedef struct packed {
      logic        accum;
      logic        load;
      logic        step;
      logic        finish;
      sym_idx_type idx;
   } dp_cmd_type;

   // Symbol order: gap, A, C, G, T, N
   function automatic logic [7:0] sym_char(input sym_idx_type idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = CHAR_GAP;
         3'd1:    c = 8'h41;
         3'd2:    c = 8'h43;
         3'd3:    c = 8'h47;
         3'd4:    c = 8'h54;
         3'd5:    c = 8'h4E;
         default: c = CHAR_GAP;
      endcase
      return c;
   endfunction

   // a beats b: higher count, or no lower count and strictly higher quality sum
   function automatic logic beats(input cnt_type ca, input qsum_type qa,
                                  input cnt_type cb, input qsum_type qb);
      return (ca > cb) || ((ca >= cb) && (qa > qb));
   endfunction

endpackage

// ===== src/cmbc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the consensus caller: accepts bases, then walks the symbol scan.
// Depends on cmbc_pkg.
module cmbc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                column_end,
   output logic                busy,
   output cmbc_pkg::dp_cmd_type cmd
);
   import cmbc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type   state_ff;
   logic        busy_ff;
   sym_idx_type idx_ff;
   logic        accept;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      cmd.accum  = accept;
      cmd.load   = (state_ff == ST_INIT);
      cmd.step   = (state_ff == ST_SCAN);
      cmd.finish = (state_ff == ST_FINISH);
      cmd.idx    = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         idx_ff   <= SYM_A;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && column_end) begin
                  state_ff <= ST_INIT;
                  busy_ff  <= 1'b1;
               end
            end
            ST_INIT: begin
               state_ff <= ST_SCAN;
               idx_ff   <= SYM_A;
            end
            ST_SCAN: begin
               if (idx_ff == SYM_LAST) begin
                  state_ff <= ST_FINISH;
               end else begin
                  idx_ff <= idx_ff + SYM_IDX_W'(1);
               end
            end
            ST_FINISH: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

endmodule

// ===== src/cmbc_datapath.sv =====
`timescale 1ns / 1ps
// Per-symbol count and quality accumulators, best/second candidate registers
// and the result register. Depends on cmbc_pkg.
module cmbc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  cmbc_pkg::dp_cmd_type cmd,
   input  logic [7:0]           base_char,
   input  logic [7:0]           base_quality,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_called_char,
   output logic                 rsp_bad_base_seen
);
   import cmbc_pkg::*;

   cnt_type     cnt_ff  [NUM_SYMBOLS];
   qsum_type    qsum_ff [NUM_SYMBOLS];
   logic        bad_ff;
   logic [NUM_SYMBOLS-1:0] hit;

   sym_idx_type best_idx_ff, next_idx_ff;
   cnt_type     best_cnt_ff, next_cnt_ff;
   qsum_type    best_q_ff, next_q_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_char_ff;
   logic        rsp_bad_ff;

   cnt_type     cur_cnt;
   qsum_type    cur_q;
   logic        beat_best, beat_next;
   logic [7:0]  call_in;

   always_comb begin
      for (int j = 0; j < NUM_SYMBOLS; j++) begin
         hit[j] = (base_char == sym_char(SYM_IDX_W'(j)));
      end
   end

   assign cur_cnt   = cnt_ff[cmd.idx];
   assign cur_q     = qsum_ff[cmd.idx];
   assign beat_best = beats(cur_cnt, cur_q, best_cnt_ff, best_q_ff);
   assign beat_next = beats(cur_cnt, cur_q, next_cnt_ff, next_q_ff);

   always_comb begin
      if (best_idx_ff == SYM_GAP) begin
         call_in = sym_char(next_idx_ff) - CHAR_UPPER + CHAR_LOWER;
      end else begin
         call_in = sym_char(best_idx_ff);
      end
   end

   // accumulator lanes
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         for (int j = 0; j < NUM_SYMBOLS; j++) begin
            cnt_ff[j]  <= '0;
            qsum_ff[j] <= '0;
         end
         bad_ff <= 1'b0;
      end else if (cmd.accum) begin
         for (int j = 0; j < NUM_SYMBOLS; j++) begin
            if (hit[j]) begin
               logic [QSUM_W:0] sum;
               sum = {1'b0, qsum_ff[j]} + (QSUM_W + 1)'(base_quality);
               if (cnt_ff[j] < CNT_MAX) begin
                  cnt_ff[j] <= cnt_ff[j] + CNT_W'(1);
               end
               qsum_ff[j] <= sum[QSUM_W] ? QSUM_MAX : sum[QSUM_W-1:0];
            end
         end
         if (hit == '0) begin
            bad_ff <= 1'b1;
         end
      end
   end

   // selection candidates
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         best_idx_ff <= SYM_GAP;
         best_cnt_ff <= cnt_ff[0];
         best_q_ff   <= qsum_ff[0];
         next_idx_ff <= SYM_A;
         next_cnt_ff <= cnt_ff[1];
         next_q_ff   <= qsum_ff[1];
      end else if (cmd.step) begin
         if (beat_best) begin
            next_idx_ff <= best_idx_ff;
            next_cnt_ff <= best_cnt_ff;
            next_q_ff   <= best_q_ff;
            best_idx_ff <= cmd.idx;
            best_cnt_ff <= cur_cnt;
            best_q_ff   <= cur_q;
         end else if (beat_next) begin
            next_idx_ff <= cmd.idx;
            next_cnt_ff <= cur_cnt;
            next_q_ff   <= cur_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_char_ff <= call_in;
         rsp_bad_ff  <= bad_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_called_char   = rsp_char_ff;
   assign rsp_bad_base_seen = rsp_bad_ff;

endmodule

// ===== src/consensus_majority_base_call.sv =====
`timescale 1ns / 1ps
// Top level of the majority-vote consensus base caller.
// Depends on cmbc_pkg, cmbc_ctrl and cmbc_datapath.
//
// Usage:
//   Bases of one alignment column are presented on req_base_char,
//   req_base_quality and req_column_end. A base transfers at a rising edge
//   where start is high and busy is low. Bases that do not close a column
//   leave busy low, so the next base may follow at once.
//   The base with req_column_end high closes the column: busy rises and
//   stays high through one load step, NUM_SYMBOLS - 1 scan steps over
//   the symbol lanes through a single comparator pair and one finish step.
//   The call appears on rsp_called_char and rsp_bad_base_seen for exactly
//   one cycle with rsp_valid high, in the cycle busy falls; a new base may
//   transfer in that same cycle. The receiver cannot stall the result.
//   Reset clears all counts, quality sums, the bad-base flag and the
//   sequencer; no result is pending after reset.
module consensus_majority_base_call (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_base_char,
   input  logic [7:0] req_base_quality,
   input  logic       req_column_end,
   output logic       rsp_valid,
   output logic [7:0] rsp_called_char,
   output logic       rsp_bad_base_seen
);
   import cmbc_pkg::*;

   dp_cmd_type cmd;

   cmbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .column_end (req_column_end),
      .busy       (busy),
      .cmd        (cmd)
   );

   cmbc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .base_char         (req_base_char),
      .base_quality      (req_base_quality),
      .rsp_valid         (rsp_valid),
      .rsp_called_char   (rsp_called_char),
      .rsp_bad_base_seen (rsp_bad_base_seen)
   );

   a_close_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_column_end) |=> busy)
      else $error("column close did not raise busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result outside the end of a busy period");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_no_accum_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.accum)
      else $error("accumulate while busy");

endmodule

// ===== verif/consensus_majority_base_call_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of consensus_majority_base_call: columns of bases go in, calls are checked.
// Depends on cmbc_pkg and the consensus_majority_base_call RTL.
module consensus_majority_base_call_test;
   import cmbc_pkg::*;

   localparam logic [7:0] BASE_A = CHAR_UPPER;
   localparam logic [7:0] BASE_C = 8'h43;
   localparam logic [7:0] BASE_G = 8'h47;
   localparam logic [7:0] BASE_T = 8'h54;
   localparam logic [7:0] BASE_N = 8'h4E;
   localparam logic [7:0] BASE_NUL = 8'h00;
   localparam logic [7:0] BASE_ALL_ONES = 8'hFF;
   localparam int RANDOM_BASES = 1625;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] called;
      logic       bad;
   } base_call_type;

   class consensus_tracker_type;
      cnt_type       counts[SYM_SLOTS];
      qsum_type      sums[SYM_SLOTS];
      logic          bad_seen;
      logic [7:0]    lane_char[SYM_SLOTS];
      base_call_type expected_calls[$];
      int            errors, bases, columns, bad_columns, gap_calls;

      function new();
         lane_char[0] = CHAR_GAP;
         lane_char[1] = BASE_A;
         lane_char[2] = BASE_C;
         lane_char[3] = BASE_G;
         lane_char[4] = BASE_T;
         lane_char[5] = BASE_N;
         errors = 0;
         bases = 0;
         columns = 0;
         bad_columns = 0;
         gap_calls = 0;
         clear();
      endfunction

      function void clear();
         foreach (counts[i]) begin
            counts[i] = '0;
            sums[i] = '0;
         end
         bad_seen = 1'b0;
      endfunction

      function int pending();
         return expected_calls.size();
      endfunction

      function bit outranks(int a, int b);
         return (counts[a] > counts[b]) || ((counts[a] >= counts[b]) && (sums[a] > sums[b]));
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH @%0t: %s", $time, msg);
      endtask

      task take_base(logic [7:0] c, logic [7:0] q, logic last);
         int              lane;
         int              top;
         int              runner_up;
         logic [QSUM_W:0] total;
         base_call_type   call;
         lane = -1;
         bases++;
         for (int i = 0; i < NUM_SYMBOLS; i++) begin
            if (lane < 0 && lane_char[i] == c) lane = i;
         end
         if (lane >= 0) begin
            if (counts[lane] < CNT_MAX) counts[lane] = counts[lane] + 1'b1;
            total = sums[lane] + q;
            sums[lane] = (total > QSUM_MAX) ? QSUM_MAX : total[QSUM_W-1:0];
         end else begin
            bad_seen = 1'b1;
         end
         if (!last) return;
         top = 0;
         runner_up = 1;
         for (int i = 1; i < NUM_SYMBOLS; i++) begin
            if (outranks(i, top)) begin
               runner_up = top;
               top = i;
            end else if (outranks(i, runner_up)) begin
               runner_up = i;
            end
         end
         call.called = lane_char[top];
         if (top == 0) begin
            call.called = lane_char[runner_up] - CHAR_UPPER + CHAR_LOWER;
            gap_calls++;
         end
         call.bad = bad_seen;
         if (bad_seen) bad_columns++;
         columns++;
         expected_calls = {expected_calls, call};
         clear();
      endtask

      task check_call(logic [7:0] c, logic b);
         base_call_type want;
         if (expected_calls.size() == 0) begin
            report($sformatf("unexpected call 0x%02h bad=%0b", c, b));
            return;
         end
         want = expected_calls.pop_front();
         if (c !== want.called)
            report($sformatf("called_char 0x%02h, want 0x%02h", c, want.called));
         if (b !== want.bad)
            report($sformatf("bad_base_seen %0b, want %0b", b, want.bad));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   logic [7:0] req_base_char;
   logic [7:0] req_base_quality;
   logic       req_column_end;
   logic       rsp_valid;
   logic [7:0] rsp_called_char;
   logic       rsp_bad_base_seen;

   consensus_tracker_type tracker;
   int burst_left = 0;
   bit bursty = 1'b0;
   int idle_cycles = 0;

   consensus_majority_base_call i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_base_char     (req_base_char),
      .req_base_quality  (req_base_quality),
      .req_column_end    (req_column_end),
      .rsp_valid         (rsp_valid),
      .rsp_called_char   (rsp_called_char),
      .rsp_bad_base_seen (rsp_bad_base_seen)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) tracker.check_call(rsp_called_char, rsp_bad_base_seen);
         if (start === 1'b1 && busy === 1'b0)
            tracker.take_base(req_base_char, req_base_quality, req_column_end);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("consensus_majority_base_call test failed");
            $finish;
         end
      end
   end

   task automatic send_base(input logic [7:0] c, input logic [7:0] q, input logic last);
      int gap;
      if (bursty && burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         start <= 1'b0;
         req_base_char <= 8'($urandom);
         req_base_quality <= 8'($urandom);
         req_column_end <= 1'($urandom);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      if (burst_left > 0) burst_left--;
      start <= 1'b1;
      req_base_char <= c;
      req_base_quality <= q;
      req_column_end <= last;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   initial begin
      int         sent;
      int         col;
      int         len;
      int         favorite;
      int         r;
      logic [7:0] c;
      logic [7:0] q;
      tracker = new();
      reset <= 1'b1;
      start <= 1'b0;
      req_base_char <= '0;
      req_base_quality <= '0;
      req_column_end <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed columns
      send_base(CHAR_GAP, 8'd0, 1'b1);
      send_base(BASE_NUL, 8'd255, 1'b1);
      send_base(BASE_A, 8'd255, 1'b1);
      send_base(BASE_C, 8'd0, 1'b1);
      send_base(BASE_G, 8'd128, 1'b1);
      send_base(BASE_T, 8'd1, 1'b1);
      send_base(BASE_N, 8'd77, 1'b1);
      send_base(CHAR_GAP, 8'd9, 1'b0);
      send_base(CHAR_GAP, 8'd9, 1'b0);
      send_base(BASE_G, 8'd255, 1'b1);
      send_base(BASE_C, 8'd10, 1'b0);
      send_base(BASE_T, 8'd20, 1'b1);
      send_base(BASE_G, 8'd5, 1'b0);
      send_base(BASE_C, 8'd5, 1'b1);
      send_base(CHAR_LOWER, 8'd3, 1'b0);
      send_base(BASE_ALL_ONES, 8'd255, 1'b0);
      send_base(BASE_T, 8'd0, 1'b1);
      send_base(CHAR_GAP, 8'd200, 1'b0);
      send_base(BASE_A, 8'd100, 1'b0);
      send_base(CHAR_GAP, 8'd1, 1'b0);
      send_base(BASE_C, 8'd250, 1'b1);
      send_base(BASE_N, 8'd255, 1'b0);
      send_base(BASE_N, 8'd255, 1'b0);
      send_base(CHAR_GAP, 8'd0, 1'b0);
      send_base(BASE_ALL_ONES, 8'd0, 1'b1);
      drain();

      // random columns, mostly valid bases around a favored symbol
      sent = 0;
      col = 0;
      while (sent < RANDOM_BASES) begin
         if (col % 16 == 0) bursty = ($urandom_range(0, 2) != 0);
         favorite = $urandom_range(0, NUM_SYMBOLS - 1);
         r = $urandom_range(0, 99);
         len = (r < 85) ? $urandom_range(1, 8) :
               (r < 97) ? $urandom_range(9, 40) : $urandom_range(41, 120);
         for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            c = (r < 45) ? tracker.lane_char[favorite] :
                (r < 90) ? tracker.lane_char[$urandom_range(0, NUM_SYMBOLS - 1)] :
                8'($urandom);
            r = $urandom_range(0, 99);
            q = (r < 10) ? 8'd0 : (r < 20) ? 8'd255 : 8'($urandom);
            send_base(c, q, k == len - 1);
         end
         sent += len;
         col++;
         if ($urandom_range(0, 29) == 0) drain();
      end
      drain();
      repeat (NUM_SYMBOLS + 4) @(posedge clock);

      $display("%0d bases in %0d columns: %0d with invalid bases, %0d gap-majority calls",
               tracker.bases, tracker.columns, tracker.bad_columns, tracker.gap_calls);
      $display("directed corner columns plus bursty random columns; %0d mismatches",
               tracker.errors);
      if (tracker.errors == 0) begin
         $display("consensus_majority_base_call test passed");
      end else begin
         $display("consensus_majority_base_call test failed");
      end
      $finish;
   end
endmodule
